/* rtl/uvs_pkg.sv */
// shared constants and types for the uv sphere tessellator
`default_nettype none

package uvs_pkg;

  localparam int MAX_SEGMENTS = 255;
  localparam int TBL_DEPTH    = MAX_SEGMENTS + 1;
  localparam int TBL_AW       = $clog2(TBL_DEPTH);

  localparam logic [7:0] SEG_CAP        = 8'(MAX_SEGMENTS);
  localparam logic [7:0] MIN_MERIDIANS  = 8'd3;
  localparam logic [7:0] MIN_PARALLELS  = 8'd2;
  localparam logic [7:0] MERIDIAN_RESET = 8'd32;
  localparam logic [7:0] PARALLEL_RESET = 8'd16;

  // register indexes
  localparam logic REG_MERIDIAN = 1'b0;
  localparam logic REG_PARALLEL = 1'b1;

  // request modes
  localparam logic MODE_VERTEX = 1'b0;
  localparam logic MODE_QUAD   = 1'b1;

  // trig table selects
  localparam logic [1:0] TRIG_SIN_U = 2'd0;
  localparam logic [1:0] TRIG_COS_U = 2'd1;
  localparam logic [1:0] TRIG_SIN_V = 2'd2;
  localparam logic [1:0] TRIG_COS_V = 2'd3;

  localparam logic [23:0] QUARTER     = 24'h400000;
  localparam logic [23:0] V_EPS_PHASE = 24'd84;
  localparam logic [25:0] V_EPS_TEX   = 26'd168;

  // odd taylor coefficients of sin, q30
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172272;

  typedef struct packed {
    logic [1:0]        sel;
    logic [TBL_AW-1:0] addr;
  } trig_tag_t;

endpackage

`default_nettype wire

/* rtl/uvs_req_if.sv */
// request channel: mode, row and col
`default_nettype none

interface uvs_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] row;
  logic [7:0] col;

  modport source (output valid, output mode, output row, output col, input ready);
  modport sink   (input valid, input mode, input row, input col, output ready);
endinterface

`default_nettype wire

/* rtl/uvs_res_if.sv */
// result channel: vertex or triangle
`default_nettype none

interface uvs_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] tex_u;
  logic [14:0]        tex_v;
  logic [15:0]        index_a;
  logic [15:0]        index_b;
  logic [15:0]        index_c;
  logic               is_triangle;
  logic               out_of_grid;
  logic               last;

  modport source (output valid, output pos_x, output pos_y, output pos_z, output tex_u,
                  output tex_v, output index_a, output index_b, output index_c,
                  output is_triangle, output out_of_grid, output last, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, input tex_u,
                  input tex_v, input index_a, input index_b, input index_c,
                  input is_triangle, input out_of_grid, input last, output ready);
endinterface

`default_nettype wire

/* rtl/uvs_sin_pipe.sv */
// pipelined q14 sine of a 24-bit turn phase, degree-9 taylor in horner form
`default_nettype none

module uvs_sin_pipe import uvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [23:0]        phase,
  input  trig_tag_t          in_tag,
  output logic               out_valid,
  output logic signed [15:0] value,
  output trig_tag_t          out_tag,
  output logic               active
);

  localparam int STAGES = 8;
  localparam logic [22:0] QTR_F   = 23'h400000;
  localparam logic [62:0] RND30   = 63'h20000000;
  localparam logic [32:0] RND16   = 33'h8000;
  localparam logic [16:0] SIN_MAX = 17'd16384;

  logic [STAGES-1:0] vld;
  trig_tag_t         tag_q [STAGES];
  logic              neg_q [STAGES];
  logic [30:0]       x30_q [0:5];
  logic [30:0]       x2_q  [1:4];
  logic [30:0]       t_q   [2:5];
  logic [31:0]       p_q;
  logic signed [15:0] val_q;

  logic [22:0] fold;
  logic [32:0] p_rnd;
  logic [16:0] s_mag;
  logic [16:0] s_clip;

  function automatic logic [31:0] mul30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] pr;
    logic [62:0] sum;
    pr  = a * b;
    sum = {1'b0, pr} + RND30;
    return sum[61:30];
  endfunction

  // quadrant fold: odd quadrants mirror about the quarter turn
  assign fold   = phase[22] ? (QTR_F - {1'b0, phase[21:0]}) : {1'b0, phase[21:0]};
  assign p_rnd  = {1'b0, p_q} + RND16;
  assign s_mag  = p_rnd[32:16];
  assign s_clip = (s_mag > SIN_MAX) ? SIN_MAX : s_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_q[0] <= in_tag;
    neg_q[0] <= phase[23];
    for (int i = 1; i < STAGES; i++) begin
      tag_q[i] <= tag_q[i-1];
      neg_q[i] <= neg_q[i-1];
    end
    x30_q[0] <= {fold, 8'd0};
    for (int i = 1; i <= 5; i++) begin
      x30_q[i] <= x30_q[i-1];
    end
    x2_q[1] <= 31'(mul30(x30_q[0], x30_q[0]));
    for (int i = 2; i <= 4; i++) begin
      x2_q[i] <= x2_q[i-1];
    end
    t_q[2] <= SIN_C7 - 31'(mul30(x2_q[1], SIN_C9));
    t_q[3] <= SIN_C5 - 31'(mul30(x2_q[2], t_q[2]));
    t_q[4] <= SIN_C3 - 31'(mul30(x2_q[3], t_q[3]));
    t_q[5] <= SIN_C1 - 31'(mul30(x2_q[4], t_q[4]));
    p_q    <= mul30(x30_q[5], t_q[5]);
    val_q  <= neg_q[6] ? -$signed({1'b0, s_clip[14:0]}) : $signed({1'b0, s_clip[14:0]});
  end

  assign out_valid = vld[STAGES-1];
  assign value     = val_q;
  assign out_tag   = tag_q[STAGES-1];
  assign active    = |vld;

endmodule

`default_nettype wire

/* rtl/uv_sphere_tessellator_unit.sv */
// Unit UV sphere tessellator: one request per cycle while the fill is idle and the output
// does not hold the pipeline; results pass through registers a, b and c. A quad request
// gives one or two triangles, so a two-triangle cell holds the output register until
// both are taken. The per-column and per-row sines, cosines and texture coordinates
// live in 256-entry tables that a fill sequencer builds after reset and after every
// register write: a divide, a setup step, a sweep of every table entry through the
// shared sine pipeline and a drain, during which no request is taken.
`default_nettype none

module uv_sphere_tessellator_unit import uvs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  uvs_req_if.sink    req,
  uvs_res_if.source  res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_INIT  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  localparam logic [4:0]  DIV_TOP = 5'd24;
  localparam logic [23:0] NUM_U14 = 24'd16384;
  localparam logic [23:0] NUM_OFF = 24'd8192;
  localparam logic [31:0] NUM_V23 = 32'h800000;
  localparam logic [25:0] QD_INIT = 26'h1000000;
  localparam logic [25:0] RND10   = 26'd512;
  localparam logic [29:0] RND14   = 30'd8192;
  localparam logic [TBL_AW-1:0] LAST_ADDR = TBL_AW'(TBL_DEPTH - 1);

  // ---------------- configuration ----------------
  logic [7:0] meridian_count;
  logic [7:0] parallel_count;
  logic [7:0] seg_w;
  logic [7:0] seg_h;
  logic [8:0] seg_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      meridian_count <= MERIDIAN_RESET;
      parallel_count <= PARALLEL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_MERIDIAN) begin
        meridian_count <= cfg_data;
      end else begin
        parallel_count <= cfg_data;
      end
    end
  end

  always_comb begin
    seg_w = (meridian_count < MIN_MERIDIANS) ? MIN_MERIDIANS : meridian_count;
    if (seg_w > SEG_CAP) seg_w = SEG_CAP;
    seg_h = (parallel_count < MIN_PARALLELS) ? MIN_PARALLELS : parallel_count;
    if (seg_h > SEG_CAP) seg_h = SEG_CAP;
  end
  assign seg_s = {1'b0, seg_w} + 9'd1;

  // ---------------- table fill sequencer ----------------
  logic [2:0]        st;
  logic [4:0]        dcnt;
  logic [7:0]        remw, remh;
  logic [24:0]       qw, qh;
  logic [TBL_AW-1:0] cnt;
  logic [1:0]        sub;

  logic [23:0] pu_step_q;  logic [7:0] pu_step_r;
  logic [15:0] u_step_q;   logic [7:0] u_step_r;
  logic [23:0] v_step_q;   logic [7:0] v_step_r;
  logic [25:0] t_step_q;   logic [7:0] t_step_r;
  logic [15:0] u_off;

  logic [23:0] qa;  logic [7:0] ra;
  logic [15:0] qb;  logic [7:0] rb;
  logic [23:0] qc;  logic [7:0] rc;
  logic [25:0] qd;  logic [7:0] rd;

  logic       div_bit;
  logic [8:0] rw_t, rh_t;
  logic [14:0] q_u14, q_off;
  logic [23:0] q_v23;
  logic [23:0] r_u14, r_off;
  logic [31:0] r_v23;
  logic [8:0]  off_chk;
  logic [8:0]  ra_s, rb_s, rc_s;
  logic [9:0]  rd_s;
  logic [9:0]  rd_fix;
  logic signed [25:0] qd_sub;
  logic [25:0] tv_rnd;
  logic [14:0] tv_fill;

  logic        sin_in_valid;
  logic [23:0] sin_phase;
  trig_tag_t   sin_in_tag;
  logic        trig_valid;
  logic signed [15:0] trig_val;
  trig_tag_t   trig_tag;
  logic        sin_active;

  assign div_bit = (dcnt == DIV_TOP);
  assign rw_t    = {remw, div_bit};
  assign rh_t    = {remh, div_bit};

  // step sizes derived from floor(2^24 / w) and floor(2^24 / h)
  assign q_u14   = qw[24:10];
  assign q_off   = {1'b0, qw[24:11]};
  assign q_v23   = qh[24:1];
  assign r_u14   = NUM_U14 - 24'(q_u14 * seg_w);
  assign r_off   = NUM_OFF - 24'(q_off * seg_w);
  assign r_v23   = NUM_V23 - 32'(q_v23 * seg_h);
  assign off_chk = {1'b0, r_off[7:0]} + {2'b0, seg_w[7:1]};

  assign ra_s   = {1'b0, ra} + {1'b0, pu_step_r};
  assign rb_s   = {1'b0, rb} + {1'b0, u_step_r};
  assign rc_s   = {1'b0, rc} + {1'b0, v_step_r};
  assign rd_s   = {2'b0, rd} - {2'b0, t_step_r};
  assign rd_fix = rd_s + {2'b0, seg_h};

  assign qd_sub  = $signed(qd) - $signed(V_EPS_TEX);
  assign tv_rnd  = qd_sub + RND10;
  assign tv_fill = qd_sub[25] ? 15'd0 : tv_rnd[24:10];

  assign sin_in_valid = (st == ST_SWEEP);
  assign sin_in_tag   = '{sel: sub, addr: cnt};

  always_comb begin
    case (sub)
      TRIG_SIN_U: sin_phase = qa;
      TRIG_COS_U: sin_phase = qa + QUARTER;
      TRIG_SIN_V: sin_phase = qc + V_EPS_PHASE;
      default:    sin_phase = qc + V_EPS_PHASE + QUARTER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      st   <= ST_DIV;
      dcnt <= DIV_TOP;
      remw <= '0;
      remh <= '0;
      qw   <= '0;
      qh   <= '0;
      cnt  <= '0;
      sub  <= '0;
    end else begin
      case (st)
        ST_DIV: begin
          // restoring divide of 2^24, one quotient bit a cycle
          if (rw_t >= {1'b0, seg_w}) begin
            remw <= 8'(rw_t - {1'b0, seg_w});
            qw   <= {qw[23:0], 1'b1};
          end else begin
            remw <= rw_t[7:0];
            qw   <= {qw[23:0], 1'b0};
          end
          if (rh_t >= {1'b0, seg_h}) begin
            remh <= 8'(rh_t - {1'b0, seg_h});
            qh   <= {qh[23:0], 1'b1};
          end else begin
            remh <= rh_t[7:0];
            qh   <= {qh[23:0], 1'b0};
          end
          if (dcnt == 5'd0) begin
            st <= ST_INIT;
          end else begin
            dcnt <= dcnt - 5'd1;
          end
        end
        ST_INIT: begin
          cnt <= '0;
          sub <= '0;
          st  <= ST_SWEEP;
        end
        ST_SWEEP: begin
          sub <= sub + 2'd1;
          if (sub == TRIG_COS_V) begin
            cnt <= cnt + TBL_AW'(1);
            if (cnt == LAST_ADDR) st <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!sin_active) st <= ST_IDLE;
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // step sizes and running quotients, no reset needed
  always_ff @(posedge clk) begin
    if (st == ST_INIT) begin
      pu_step_q <= qw[23:0];
      pu_step_r <= remw;
      u_step_q  <= 16'(q_u14);
      u_step_r  <= r_u14[7:0];
      v_step_q  <= q_v23;
      v_step_r  <= r_v23[7:0];
      t_step_q  <= 26'(qh);
      t_step_r  <= remh;
      u_off     <= 16'(q_off) + ((off_chk >= {1'b0, seg_w}) ? 16'd1 : 16'd0);
      qa <= '0;  ra <= {1'b0, seg_w[7:1]};
      qb <= '0;  rb <= {1'b0, seg_w[7:1]};
      qc <= '0;  rc <= {1'b0, seg_h[7:1]};
      qd <= QD_INIT;  rd <= '0;
    end else if (st == ST_SWEEP && sub == TRIG_COS_V) begin
      if (ra_s >= {1'b0, seg_w}) begin
        qa <= qa + pu_step_q + 24'd1;
        ra <= 8'(ra_s - {1'b0, seg_w});
      end else begin
        qa <= qa + pu_step_q;
        ra <= ra_s[7:0];
      end
      if (rb_s >= {1'b0, seg_w}) begin
        qb <= qb + u_step_q + 16'd1;
        rb <= 8'(rb_s - {1'b0, seg_w});
      end else begin
        qb <= qb + u_step_q;
        rb <= rb_s[7:0];
      end
      if (rc_s >= {1'b0, seg_h}) begin
        qc <= qc + v_step_q + 24'd1;
        rc <= 8'(rc_s - {1'b0, seg_h});
      end else begin
        qc <= qc + v_step_q;
        rc <= rc_s[7:0];
      end
      // (h - row) * 2^24 / h counts down
      if (rd_s[9]) begin
        qd <= qd - t_step_q - 26'd1;
        rd <= rd_fix[7:0];
      end else begin
        qd <= qd - t_step_q;
        rd <= rd_s[7:0];
      end
    end
  end

  uvs_sin_pipe u_sin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sin_in_valid),
    .phase     (sin_phase),
    .in_tag    (sin_in_tag),
    .out_valid (trig_valid),
    .value     (trig_val),
    .out_tag   (trig_tag),
    .active    (sin_active)
  );

  // ---------------- request pipeline ----------------
  logic a_valid, b_valid, c_valid;
  logic a_en, b_en, c_en;
  logic take;
  logic c_last;

  logic signed [15:0] sin_u_mem [TBL_DEPTH];
  logic signed [15:0] cos_u_mem [TBL_DEPTH];
  logic signed [15:0] sin_v_mem [TBL_DEPTH];
  logic signed [15:0] cos_v_mem [TBL_DEPTH];
  logic [15:0]        u14_mem   [TBL_DEPTH];
  logic [14:0]        texv_mem  [TBL_DEPTH];

  logic signed [15:0] a_su, a_cu, a_sv, a_cv;
  logic [15:0]        a_u14;
  logic [14:0]        a_tv;
  logic               a_mode, a_oog, a_top, a_bot, a_hm1;
  logic [7:0]         a_row, a_col;

  logic               in_oog;

  logic [29:0]        b_xm, b_zm;
  logic               b_xn, b_zn;
  logic signed [15:0] b_y, b_tu;
  logic [14:0]        b_tv;
  logic [15:0]        b_base;
  logic               b_mode, b_oog, b_top, b_hm1;
  logic [7:0]         b_col;

  logic [14:0] mag_cu, mag_su, mag_sv;
  logic [15:0] tu_adj;
  logic [29:0] x_rnd, z_rnd;
  logic [15:0] x_mag, z_mag;
  logic        vert, is_tri;
  logic [15:0] ib_n, ic_n;

  logic signed [15:0] c_x, c_y, c_z, c_tu;
  logic [14:0]        c_tv;
  logic [15:0]        c_ia, c_ib, c_ic, c_id;
  logic               c_tri, c_oog, c_top, c_two, c_sent;

  assign c_last = !(c_two && !c_sent);
  assign c_en   = !c_valid || (res.ready && c_last);
  assign b_en   = !b_valid || c_en;
  assign a_en   = !a_valid || b_en;
  assign req.ready = (st == ST_IDLE) && a_en;
  assign take   = req.valid && req.ready;

  assign in_oog = (req.mode == MODE_VERTEX) ? (req.row > seg_h || req.col > seg_w)
                                            : (req.row >= seg_h || req.col >= seg_w);

  // tables: one write port from the fill, one read port per request
  always_ff @(posedge clk) begin
    if (trig_valid) begin
      case (trig_tag.sel)
        TRIG_SIN_U: sin_u_mem[trig_tag.addr] <= trig_val;
        TRIG_COS_U: cos_u_mem[trig_tag.addr] <= trig_val;
        TRIG_SIN_V: sin_v_mem[trig_tag.addr] <= trig_val;
        default:    cos_v_mem[trig_tag.addr] <= trig_val;
      endcase
    end
    if (st == ST_SWEEP && sub == TRIG_SIN_U) begin
      u14_mem[cnt]  <= qb;
      texv_mem[cnt] <= tv_fill;
    end
    if (a_en) begin
      a_su  <= sin_u_mem[req.col];
      a_cu  <= cos_u_mem[req.col];
      a_u14 <= u14_mem[req.col];
      a_sv  <= sin_v_mem[req.row];
      a_cv  <= cos_v_mem[req.row];
      a_tv  <= texv_mem[req.row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      c_sent  <= 1'b0;
    end else begin
      if (a_en) a_valid <= take;
      if (b_en) b_valid <= a_valid;
      if (c_en) begin
        c_valid <= b_valid;
        c_sent  <= 1'b0;
      end else if (res.ready && !c_last) begin
        c_sent <= 1'b1;
      end
    end
  end

  // stage a: request fields and flags
  always_ff @(posedge clk) begin
    if (a_en) begin
      a_mode <= req.mode;
      a_row  <= req.row;
      a_col  <= req.col;
      a_oog  <= in_oog;
      a_top  <= (req.row == 8'd0);
      a_bot  <= (req.row == seg_h);
      a_hm1  <= (req.row == seg_h - 8'd1);
    end
  end

  // stage b: magnitude products, row base, pole offset
  assign mag_cu = a_cu[15] ? 15'(-a_cu) : a_cu[14:0];
  assign mag_su = a_su[15] ? 15'(-a_su) : a_su[14:0];
  assign mag_sv = a_sv[15] ? 15'(-a_sv) : a_sv[14:0];

  always_comb begin
    if (a_top) begin
      tu_adj = a_u14 + u_off;
    end else if (a_bot) begin
      tu_adj = a_u14 - u_off;
    end else begin
      tu_adj = a_u14;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_xm   <= mag_cu * mag_sv;
      b_zm   <= mag_su * mag_sv;
      b_xn   <= a_cu[15] ^ a_sv[15];
      b_zn   <= a_su[15] ^ a_sv[15];
      b_y    <= a_cv;
      b_tu   <= $signed(tu_adj);
      b_tv   <= a_tv;
      b_base <= {8'd0, a_row} * {7'd0, seg_s};
      b_mode <= a_mode;
      b_oog  <= a_oog;
      b_top  <= a_top;
      b_hm1  <= a_hm1;
      b_col  <= a_col;
    end
  end

  // stage c: output register
  assign x_rnd  = b_xm + RND14;
  assign z_rnd  = b_zm + RND14;
  assign x_mag  = {1'b0, x_rnd[28:14]};
  assign z_mag  = {1'b0, z_rnd[28:14]};
  assign vert   = (b_mode == MODE_VERTEX) && !b_oog;
  assign is_tri = (b_mode == MODE_QUAD) && !b_oog;
  assign ib_n   = b_base + {8'd0, b_col};
  assign ic_n   = ib_n + {7'd0, seg_s};

  always_ff @(posedge clk) begin
    if (c_en) begin
      c_x   <= vert ? (b_xn ? -$signed(x_mag) : $signed(x_mag)) : 16'sd0;
      c_z   <= vert ? (b_zn ? -$signed(z_mag) : $signed(z_mag)) : 16'sd0;
      c_y   <= vert ? b_y : 16'sd0;
      c_tu  <= vert ? b_tu : 16'sd0;
      c_tv  <= vert ? b_tv : 15'd0;
      c_ia  <= is_tri ? ib_n + 16'd1 : 16'd0;
      c_ib  <= is_tri ? ib_n : 16'd0;
      c_ic  <= is_tri ? ic_n : 16'd0;
      c_id  <= is_tri ? ic_n + 16'd1 : 16'd0;
      c_tri <= is_tri;
      c_oog <= b_oog;
      c_top <= b_top;
      // inner cells give both triangles
      c_two <= is_tri && !b_top && !b_hm1;
    end
  end

  assign res.valid       = c_valid;
  assign res.pos_x       = c_x;
  assign res.pos_y       = c_y;
  assign res.pos_z       = c_z;
  assign res.tex_u       = c_tu;
  assign res.tex_v       = c_tv;
  // first triangle (a,b,d) unless top row or already sent, else (b,c,d)
  assign res.index_a     = (!c_top && !c_sent) ? c_ia : c_ib;
  assign res.index_b     = (!c_top && !c_sent) ? c_ib : c_ic;
  assign res.index_c     = c_id;
  assign res.is_triangle = c_tri;
  assign res.out_of_grid = c_oog;
  assign res.last        = c_last;

endmodule

`default_nettype wire
